/* rtl/mffw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mffw_pkg
// Shared types and constants of the multi-format framebuffer writer.
// ----------------------------------------------------------------------------
package mffw_pkg;

   // Default frame store geometry.
   localparam int DEF_MAX_WIDTH  = 320;
   localparam int DEF_MAX_HEIGHT = 240;

   // Register reset values.
   localparam logic [8:0] RST_FRAME_WIDTH  = 9'd320;
   localparam logic [7:0] RST_FRAME_HEIGHT = 8'd240;

   // Operation codes.
   localparam logic [1:0] OP_PLOT = 2'd0;
   localparam logic [1:0] OP_FILL = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Stored pixel formats. The fourth code behaves as RGB332.
   localparam logic [1:0] FMT_RGB565 = 2'd0;
   localparam logic [1:0] FMT_RGB444 = 2'd1;
   localparam logic [1:0] FMT_RGB332 = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CLIP,
      S_PIX_MUL,
      S_WR0,
      S_WR1,
      S_RD_N,
      S_RD_ADDR,
      S_RD_DATA
   } state_type;

endpackage

`default_nettype wire

/* rtl/mffw_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mffw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mffw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/multi_format_framebuffer_writer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multi_format_framebuffer_writer_top
// Byte-wide frame store with a clipped pixel plotter, a rectangle filler and a
// scan-out byte reader. Pixels are stored as RGB565, packed RGB444 or RGB332.
// ----------------------------------------------------------------------------
// A read beat runs S_RD_N, S_RD_ADDR and S_RD_DATA with busy high, and its
// strobe is registered from S_RD_DATA. A plot or fill keeps busy high to clip,
// then per pixel for S_PIX_MUL (row multiplier), S_WR0, and S_WR1 in RGB565
// and RGB444 (single write port). Reset clears all MAX_WIDTH*MAX_HEIGHT*2 store
// bytes (153600 by default) with busy high, while taking configuration writes.
// The receiver cannot stall: each result shows on the rsp_ ports for one cycle.

module multi_format_framebuffer_writer_top
   import mffw_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Command channel.
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [1:0]  req_op,
   input  wire logic signed [15:0] req_x_pos,
   input  wire logic signed [15:0] req_y_pos,
   input  wire logic signed [15:0] req_rect_width,
   input  wire logic signed [15:0] req_rect_height,
   input  wire logic        [15:0] req_color,
   input  wire logic        [17:0] req_read_address,
   // Result channel.
   output logic                    rsp_strobe,
   output logic             [7:0]  rsp_read_byte,
   // Configuration channel.
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic        [1:0]  csr_index,
   input  wire logic        [8:0]  csr_data
);

   // The store holds two bytes per pixel of the largest frame.
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;

   logic [8:0]         frame_width_ff;
   logic [7:0]         frame_height_ff;
   logic [1:0]         pixel_format_ff;

   // Captured command.
   logic signed [15:0] x_ff, x_in;
   logic signed [15:0] y_ff, y_in;
   logic signed [15:0] w_ff, w_in;
   logic signed [15:0] h_ff, h_in;
   logic [15:0]        color_ff, color_in;
   logic [17:0]        addr_ff, addr_in;

   // Fill cursor, inclusive bounds.
   logic [8:0]         cur_x_ff, cur_x_in;
   logic [7:0]         cur_y_ff, cur_y_in;
   logic [8:0]         x0_ff, x0_in;
   logic [8:0]         end_x_ff, end_x_in;
   logic [7:0]         end_y_ff, end_y_in;

   // Linear pixel index and frame pixel count.
   logic [16:0]        p_ff, p_in;
   logic [16:0]        n_ff, n_in;

   // Read pipeline.
   logic               in_range_ff, in_range_in;
   logic               lo_ff, lo_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;

   // RAM port signals.
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [7:0]         ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [7:0]         ram_rdata;

   // ------------------------------------------------------------------------
   // Derived values
   // ------------------------------------------------------------------------
   logic [8:0]         aw;
   logic [7:0]         ah;
   logic               accept;
   logic               last_pix;
   logic               two_writes;
   logic               pix_done;

   // A size register above the store geometry counts as the store geometry.
   assign aw = (32'(frame_width_ff) > MAX_WIDTH) ? 9'(MAX_WIDTH) : frame_width_ff;
   assign ah = (32'(frame_height_ff) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : frame_height_ff;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_byte = rsp_byte_ff;

   assign last_pix = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);

   // RGB565 and packed RGB444 write each pixel in S_WR0 and S_WR1.
   assign two_writes = (pixel_format_ff == FMT_RGB565) || (pixel_format_ff == FMT_RGB444);
   assign pix_done   = ((state_ff == S_WR0) && !two_writes) || (state_ff == S_WR1);

   // Clip the rectangle to the frame. A plot is a one by one rectangle, so it
   // takes the same path and falls out as empty when it lies outside.
   logic signed [18:0] cx, cy, cw, ch, fw_s, fh_s;
   logic               clip_empty;

   always_comb begin
      fw_s = signed'({10'd0, aw});
      fh_s = signed'({11'd0, ah});
      cx   = 19'(x_ff);
      cy   = 19'(y_ff);
      cw   = 19'(w_ff);
      ch   = 19'(h_ff);
      if (cx < 19'sd0) begin
         cw = cw + cx;
         cx = '0;
      end
      if (cy < 19'sd0) begin
         ch = ch + cy;
         cy = '0;
      end
      if (cx + cw > fw_s) begin
         cw = fw_s - cx;
      end
      if (cy + ch > fh_s) begin
         ch = fh_s - cy;
      end
      clip_empty = (cw <= 19'sd0) || (ch <= 19'sd0);
   end

   // Byte addresses of the current pixel. In RGB444 a pixel pair occupies
   // three bytes starting at 3 * (p / 2).
   logic [15:0]        half_p;
   logic [17:0]        trip_addr;
   logic [17:0]        wr_addr_a, wr_addr_b;
   logic [3:0]         r4, g4, b4;

   assign half_p    = p_ff[16:1];
   assign trip_addr = {2'b00, half_p} + {1'b0, half_p, 1'b0};
   assign r4        = color_ff[15:12];
   assign g4        = color_ff[10:7];
   assign b4        = color_ff[4:1];

   // Scan-out limit: two bytes per pixel, or one and a half in RGB444 with an
   // odd last pixel rounded up.
   logic [18:0]        n3, limit;
   logic [17:0]        rd_byte_addr;

   assign n3 = {2'b00, n_ff} + {1'b0, n_ff, 1'b0};

   always_comb begin
      if (pixel_format_ff == FMT_RGB444) begin
         limit = (n3 + 19'd1) >> 1;
      end else begin
         limit = {1'b0, n_ff, 1'b0};
      end
   end

   // RGB332 expansion back to RGB565 by bit replication.
   logic [15:0]        px565;

   assign px565 = {ram_rdata[7:5], ram_rdata[7:6],
                   ram_rdata[4:2], ram_rdata[4:2],
                   ram_rdata[1:0], ram_rdata[1:0], ram_rdata[1]};

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_PLOT, OP_FILL: state_in = S_CLIP;
                  OP_READ:          state_in = S_RD_N;
                  default:          state_in = S_IDLE;
               endcase
            end
         end
         S_CLIP:    state_in = clip_empty ? S_IDLE : S_PIX_MUL;
         S_PIX_MUL: state_in = S_WR0;
         S_WR0: begin
            if (two_writes) begin
               state_in = S_WR1;
            end else begin
               state_in = last_pix ? S_IDLE : S_PIX_MUL;
            end
         end
         S_WR1:     state_in = last_pix ? S_IDLE : S_PIX_MUL;
         S_RD_N:    state_in = S_RD_ADDR;
         S_RD_ADDR: state_in = S_RD_DATA;
         S_RD_DATA: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      clr_in        = clr_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      color_in      = color_ff;
      addr_in       = addr_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      x0_in         = x0_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      in_range_in   = in_range_ff;
      lo_in         = lo_ff;
      rsp_strobe_in = 1'b0;
      rsp_byte_in   = rsp_byte_ff;

      if (state_ff == S_CLEAR) begin
         clr_in = clr_ff + AW'(1);
      end

      if (accept) begin
         x_in     = req_x_pos;
         y_in     = req_y_pos;
         color_in = req_color;
         addr_in  = req_read_address;
         if (req_op == OP_FILL) begin
            w_in = req_rect_width;
            h_in = req_rect_height;
         end else begin
            w_in = 16'sd1;
            h_in = 16'sd1;
         end
      end

      if (state_ff == S_CLIP) begin
         cur_x_in = cx[8:0];
         x0_in    = cx[8:0];
         cur_y_in = cy[7:0];
         end_x_in = 9'(cx + cw - 19'sd1);
         end_y_in = 8'(cy + ch - 19'sd1);
      end

      if (state_ff == S_PIX_MUL) begin
         p_in = 17'({9'd0, cur_y_ff} * {8'd0, aw}) + {8'd0, cur_x_ff};
      end

      // Raster order: left to right, then the next row.
      if (pix_done && !last_pix) begin
         if (cur_x_ff == end_x_ff) begin
            cur_x_in = x0_ff;
            cur_y_in = cur_y_ff + 8'd1;
         end else begin
            cur_x_in = cur_x_ff + 9'd1;
         end
      end

      if (state_ff == S_RD_N) begin
         n_in = {9'd0, ah} * {8'd0, aw};
      end

      if (state_ff == S_RD_ADDR) begin
         in_range_in = {1'b0, addr_ff} < limit;
         lo_in       = addr_ff[0];
      end

      if (state_ff == S_RD_DATA) begin
         rsp_strobe_in = 1'b1;
         if (!in_range_ff) begin
            rsp_byte_in = '0;
         end else if ((pixel_format_ff == FMT_RGB565) || (pixel_format_ff == FMT_RGB444)) begin
            rsp_byte_in = ram_rdata;
         end else begin
            rsp_byte_in = lo_ff ? px565[7:0] : px565[15:8];
         end
      end
   end

   // ------------------------------------------------------------------------
   // RAM port control
   // ------------------------------------------------------------------------
   // An RGB444 pixel shares one byte with its neighbor. In S_WR0 the block
   // reads that byte while writing the pixel's own byte; S_WR1 then
   // merges the kept nibble and writes it back. The next pixel only reads the
   // shared byte after this write, so no forwarding is needed.
   always_comb begin
      ram_we       = 1'b0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      wr_addr_a    = '0;
      wr_addr_b    = '0;
      rd_byte_addr = '0;
      ram_waddr    = '0;
      ram_raddr    = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
         end
         S_WR0: begin
            ram_we = 1'b1;
            unique case (pixel_format_ff)
               FMT_RGB565: begin
                  wr_addr_a = {p_ff, 1'b0};
                  ram_wdata = color_ff[15:8];
               end
               FMT_RGB444: begin
                  ram_re       = 1'b1;
                  rd_byte_addr = trip_addr + 18'd1;
                  if (!p_ff[0]) begin
                     wr_addr_a = trip_addr;
                     ram_wdata = {r4, g4};
                  end else begin
                     wr_addr_a = trip_addr + 18'd2;
                     ram_wdata = {g4, b4};
                  end
               end
               default: begin
                  wr_addr_a = {1'b0, p_ff};
                  ram_wdata = {color_ff[15:13], color_ff[10:8], color_ff[4:3]};
               end
            endcase
            ram_waddr = AW'(wr_addr_a);
            ram_raddr = AW'(rd_byte_addr);
         end
         S_WR1: begin
            ram_we = 1'b1;
            if (pixel_format_ff == FMT_RGB444) begin
               wr_addr_b = trip_addr + 18'd1;
               ram_wdata = p_ff[0] ? {ram_rdata[7:4], r4} : {b4, ram_rdata[3:0]};
            end else begin
               wr_addr_b = {p_ff, 1'b1};
               ram_wdata = color_ff[7:0];
            end
            ram_waddr = AW'(wr_addr_b);
         end
         S_RD_ADDR: begin
            ram_re = 1'b1;
            if ((pixel_format_ff == FMT_RGB565) || (pixel_format_ff == FMT_RGB444)) begin
               rd_byte_addr = addr_ff;
            end else begin
               rd_byte_addr = addr_ff >> 1;
            end
            // Out-of-frame reads are steered to a harmless address.
            if ({1'b0, addr_ff} < limit) begin
               ram_raddr = AW'(rd_byte_addr);
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   mffw_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------------------
   // Sequential logic
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         rsp_strobe_ff   <= 1'b0;
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         pixel_format_ff <= FMT_RGB565;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[7:0];
               CSR_PIXEL_FORMAT: pixel_format_ff <= csr_data[1:0];
               default:          frame_width_ff  <= frame_width_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      color_ff    <= color_in;
      addr_ff     <= addr_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      x0_ff       <= x0_in;
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      in_range_ff <= in_range_in;
      lo_ff       <= lo_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTH
   // Every accepted read beat returns a strobe after S_RD_N, S_RD_ADDR, S_RD_DATA.
   a_read_latency : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_READ)) |-> ##4 rsp_strobe)
      else $error("read beat did not produce a result strobe");

   // A strobe only ever follows the read data cycle.
   a_strobe_source : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_RD_DATA))
      else $error("result strobe without a read");

   // The fill cursor never leaves the clipped rectangle while pixels are written.
   a_cursor_bounds : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_PIX_MUL) || (state_ff == S_WR0) || (state_ff == S_WR1)) |->
      ((cur_x_ff <= end_x_ff) && (cur_y_ff <= end_y_ff) && (cur_x_ff < aw) && (cur_y_ff < ah)))
      else $error("fill cursor outside the frame");

   // The clearing pass stays inside the store.
   a_clear_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (clr_ff <= AW'(DEPTH - 1)))
      else $error("clearing pass beyond the store");

   // The store is not written while waiting for a command.
   a_idle_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we)
      else $error("store written while idle");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-format framebuffer writer. A shadow copy
// of the frame store is updated on every accepted plot and fill beat, and each
// read beat queues the scan-out byte it must return. Directed tests cover
// clipping, full-frame fills, the RGB444 shared nibble, RGB332 expansion,
// oversized and empty frames; random phases then mix plots, fills and reads
// under several frame settings with varying sender gaps.
// ----------------------------------------------------------------------------

module tb_top;
   import mffw_pkg::*;

   // The op code that the block takes and ignores.
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam int STORE_BYTES = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * 2;

   // The slowest correct run is the clearing pass, one full-frame fill in RGB565
   // and under 2000 beats, each at most a fill of a frame of up to 512 pixels
   // plus the sender gaps. The limit is several times that.
   localparam int TIMEOUT_CYCLES = 15_000_000;

   typedef struct {
      logic        [1:0]  op;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] rect_width;
      logic signed [15:0] rect_height;
      logic        [15:0] color;
      logic        [17:0] read_address;
   } draw_cmd_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic        [1:0]  req_op;
   logic signed [15:0] req_x_pos;
   logic signed [15:0] req_y_pos;
   logic signed [15:0] req_rect_width;
   logic signed [15:0] req_rect_height;
   logic        [15:0] req_color;
   logic        [17:0] req_read_address;
   logic               rsp_strobe;
   logic        [7:0]  rsp_read_byte;
   logic               csr_valid;
   logic               csr_ready;
   logic        [1:0]  csr_index;
   logic        [8:0]  csr_data;

   multi_format_framebuffer_writer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_color        (req_color),
      .req_read_address (req_read_address),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_byte    (rsp_read_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Shadow state: the frame store, the three registers, and the scan-out
   // bytes that accepted read beats still owe us, oldest first.
   logic [7:0] frame_bytes [STORE_BYTES];
   logic [8:0] cfg_width;
   logic [7:0] cfg_height;
   logic [1:0] cfg_format;
   logic [7:0] expected_bytes [$];

   int fail_count;
   int sender_idle_pct;
   // Index of the pixel most recently written, so reads can aim at fresh data.
   int last_pixel;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ----------------------------------------------------------------------
   // Shadow model of the block.
   // ----------------------------------------------------------------------

   // Size registers above the store geometry saturate to it.
   function automatic int frame_cols();
      return (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(cfg_width);
   endfunction

   function automatic int frame_rows();
      return (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(cfg_height);
   endfunction

   // Number of bytes in the scan-out stream. Packed RGB444 rounds up so that
   // an odd last pixel can still be read.
   function automatic int scan_length();
      int pixels;
      pixels = frame_cols() * frame_rows();
      if (cfg_format == FMT_RGB444)
         return (pixels * 3 + 1) / 2;
      return pixels * 2;
   endfunction

   // Writes one pixel already known to be inside the frame.
   function automatic void store_pixel(input int col, input int row, input logic [15:0] c);
      int p;
      int b;
      p = row * frame_cols() + col;
      last_pixel = p;
      case (cfg_format)
         FMT_RGB565: begin
            frame_bytes[2 * p]     = c[15:8];
            frame_bytes[2 * p + 1] = c[7:0];
         end
         FMT_RGB444: begin
            // Two pixels share three bytes; the middle byte holds blue of the
            // even pixel in its high nibble and red of the odd one in its low.
            b = (p >> 1) * 3;
            if (p % 2 == 0) begin
               frame_bytes[b]     = {c[15:12], c[10:7]};
               frame_bytes[b + 1] = {c[4:1], frame_bytes[b + 1][3:0]};
            end else begin
               frame_bytes[b + 1] = {frame_bytes[b + 1][7:4], c[15:12]};
               frame_bytes[b + 2] = {c[10:7], c[4:1]};
            end
         end
         default: frame_bytes[p] = {c[15:13], c[10:8], c[4:3]};
      endcase
   endfunction

   function automatic void plot_pixel(input int x, input int y, input logic [15:0] c);
      if (x < 0 || y < 0 || x >= frame_cols() || y >= frame_rows())
         return;
      store_pixel(x, y, c);
   endfunction

   function automatic void fill_rect(input int x, input int y, input int w, input int h,
                                     input logic [15:0] c);
      if (x < 0) begin
         w = w + x;
         x = 0;
      end
      if (y < 0) begin
         h = h + y;
         y = 0;
      end
      if (x + w > frame_cols())
         w = frame_cols() - x;
      if (y + h > frame_rows())
         h = frame_rows() - y;
      if (w <= 0 || h <= 0)
         return;
      for (int r = 0; r < h; r++)
         for (int k = 0; k < w; k++)
            store_pixel(x + k, y + r, c);
   endfunction

   // RGB332 bytes are widened to big-endian RGB565 by repeating their bits.
   function automatic logic [7:0] scan_byte(input logic [17:0] addr);
      int a;
      logic [7:0] v;
      logic [15:0] px;
      a = int'(addr);
      if (a >= scan_length())
         return 8'h00;
      if (cfg_format == FMT_RGB565 || cfg_format == FMT_RGB444)
         return frame_bytes[a];
      v = frame_bytes[a >> 1];
      px = {v[7:5], v[7:6], v[4:2], v[4:2], v[1:0], v[1:0], v[1]};
      return addr[0] ? px[7:0] : px[15:8];
   endfunction

   function automatic void predict_cmd(input draw_cmd_type c);
      case (c.op)
         OP_PLOT: plot_pixel(c.x_pos, c.y_pos, c.color);
         OP_FILL: fill_rect(c.x_pos, c.y_pos, c.rect_width, c.rect_height, c.color);
         OP_READ: expected_bytes.push_back(scan_byte(c.read_address));
         default: ;
      endcase
   endfunction

   // ----------------------------------------------------------------------
   // Drivers.
   // ----------------------------------------------------------------------

   function automatic draw_cmd_type make_cmd(input logic [1:0] op, input int x, input int y,
                                             input int w, input int h, input int color,
                                             input int addr);
      draw_cmd_type c;
      c.op           = op;
      c.x_pos        = 16'(x);
      c.y_pos        = 16'(y);
      c.rect_width   = 16'(w);
      c.rect_height  = 16'(h);
      c.color        = 16'(color);
      c.read_address = 18'(addr);
      return c;
   endfunction

   // Sends one beat. Called at a falling edge and returns at a falling edge
   // with start still high, so back-to-back beats never pulse it low. Gaps
   // are drawn cycle by cycle so they land on every phase of the work.
   task automatic send_cmd(input draw_cmd_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_op           <= c.op;
      req_x_pos        <= c.x_pos;
      req_y_pos        <= c.y_pos;
      req_rect_width   <= c.rect_width;
      req_rect_height  <= c.rect_height;
      req_color        <= c.color;
      req_read_address <= c.read_address;
      do @(posedge clock); while (busy);
      predict_cmd(c);
      @(negedge clock);
   endtask

   // Stops sending and waits until every owed byte has come back and the
   // block has finished its last plot or fill. The extra wait that follows
   // covers a read whose strobe trails the drop of busy.
   task automatic wait_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0 || busy);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes all three registers while the block is idle. Valid stays high
   // across the three beats.
   task automatic program_frame(input logic [8:0] w, input logic [7:0] h,
                                input logic [1:0] fmt);
      logic [1:0] regs [3];
      logic [8:0] vals [3];
      regs[0] = CSR_FRAME_WIDTH;
      regs[1] = CSR_FRAME_HEIGHT;
      regs[2] = CSR_PIXEL_FORMAT;
      vals[0] = w;
      vals[1] = {1'b0, h};
      vals[2] = {7'b0, fmt};
      wait_until_drained();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (regs[i])
            CSR_FRAME_WIDTH:  cfg_width  = vals[i];
            CSR_FRAME_HEIGHT: cfg_height = vals[i][7:0];
            default:          cfg_format = vals[i][1:0];
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // ----------------------------------------------------------------------
   // Result checker. The receiver cannot stall, so every strobe is a beat.
   // ----------------------------------------------------------------------
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: read byte %02h with no read outstanding", $time, rsp_read_byte);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_read_byte !== want) begin
               $display("%0t: read_byte mismatch, expected %02h, actual %02h",
                        $time, want, rsp_read_byte);
               fail_count++;
            end
         end
      end
   end

   // ----------------------------------------------------------------------
   // Directed tests.
   // ----------------------------------------------------------------------

   // The store comes out of reset cleared; op code 3 is taken and dropped.
   task automatic test_cleared_store();
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_NONE, 3, 3, 3, 3, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 18'h3FFFF));
   endtask

   // Plots at the last pixel land; plots past right, bottom, left edges drop.
   task automatic test_plot_clipping();
      send_cmd(make_cmd(OP_PLOT, 319, 239, 0, 0, 16'hA5C3, 0));
      send_cmd(make_cmd(OP_PLOT, 320, 0, 0, 0, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_PLOT, 0, 240, 0, 0, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_PLOT, -1, 5, 0, 0, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_PLOT, -32768, 32767, 0, 0, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES - 2));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
   endtask

   // One fill clipped on all four sides covers the whole default frame; empty
   // and negative sizes draw nothing.
   task automatic test_full_frame_fill();
      send_cmd(make_cmd(OP_FILL, -5, -5, 32767, 32767, 16'h8001, 0));
      send_cmd(make_cmd(OP_FILL, 0, 0, 0, 5, 16'h1234, 0));
      send_cmd(make_cmd(OP_FILL, 0, 0, 4, -32768, 16'h1234, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES));
   endtask

   // A 3x3 packed frame has an odd pixel count, so the last pixel ends on a
   // half byte that must still be readable. Each plot of the first pair must
   // keep the other pixel's nibble in the shared byte.
   task automatic test_rgb444_shared_nibble();
      program_frame(9'd3, 8'd3, FMT_RGB444);
      send_cmd(make_cmd(OP_PLOT, 1, 0, 0, 0, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_PLOT, 0, 0, 0, 0, 16'h0000, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 1));
      send_cmd(make_cmd(OP_FILL, 2, 2, 1, 1, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 13));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 14));
   endtask

   // The unused format code acts as RGB332, and size registers above the
   // store geometry saturate to it.
   task automatic test_rgb332_oversized();
      program_frame(9'd511, 8'd255, OP_NONE);
      send_cmd(make_cmd(OP_PLOT, 5, 0, 0, 0, 16'hE71C, 0));
      send_cmd(make_cmd(OP_PLOT, 320, 0, 0, 0, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_PLOT, 319, 239, 0, 0, 16'h07E0, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 10));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 11));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
   endtask

   // A zero size makes the frame empty: nothing is drawn and reads give 0,
   // although the store still holds data.
   task automatic test_empty_frame();
      program_frame(9'd0, 8'd0, FMT_RGB565);
      send_cmd(make_cmd(OP_PLOT, 0, 0, 0, 0, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_FILL, 0, 0, 5, 5, 16'hFFFF, 0));
      send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
   endtask

   // ----------------------------------------------------------------------
   // Random traffic.
   // ----------------------------------------------------------------------

   // A value from two below zero to two past the limit, so edges are hit often.
   function automatic logic [15:0] around(input int limit);
      return 16'($urandom_range(limit + 4)) - 16'd2;
   endfunction

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int cols;
      int rows;
      int pick;
      int base;
      bit roomy;
      cols  = frame_cols();
      rows  = frame_rows();
      // Only in small frames may a fill take a full 16-bit size, since a
      // clipped fill of a big frame writes every pixel of the frame one by one.
      roomy = (cols * rows <= 512);
      pick  = $urandom_range(99);
      if (pick < 35)
         c.op = OP_PLOT;
      else if (pick < 55)
         c.op = OP_FILL;
      else if (pick < 95)
         c.op = OP_READ;
      else
         c.op = OP_NONE;
      c.x_pos = ($urandom_range(99) < 85) ? around(cols) : 16'($urandom);
      c.y_pos = ($urandom_range(99) < 85) ? around(rows) : 16'($urandom);
      if (roomy && $urandom_range(99) < 20) begin
         c.rect_width  = 16'($urandom);
         c.rect_height = 16'($urandom);
      end else if (roomy) begin
         c.rect_width  = around(cols);
         c.rect_height = around(rows);
      end else begin
         c.rect_width  = around(12);
         c.rect_height = around(12);
      end
      c.color = 16'($urandom);
      // Reads mostly aim at the scan-out range or at the freshest pixel.
      pick = $urandom_range(99);
      base = (cfg_format == FMT_RGB444) ? (last_pixel >> 1) * 3 : last_pixel * 2;
      if (pick < 20)
         c.read_address = 18'($urandom);
      else if (pick < 50)
         c.read_address = 18'(base + $urandom_range(2));
      else
         c.read_address = 18'($urandom_range(scan_length() + 2));
      return c;
   endfunction

   // One setting of the registers and a run of beats under it. Halfway the
   // sender holds off until every read has been answered.
   task automatic run_random_phase(input int n_beats);
      draw_cmd_type c;
      int pick;
      int sent;
      logic [8:0] w;
      logic [7:0] h;
      pick = $urandom_range(99);
      if (pick < 75)
         w = 9'($urandom_range(1, 16));
      else if (pick < 83)
         w = 9'd320;
      else if (pick < 90)
         w = 9'd511;
      else if (pick < 95)
         w = 9'd1;
      else
         w = 9'($urandom_range(1, 511));
      pick = $urandom_range(99);
      if (pick < 75)
         h = 8'($urandom_range(1, 12));
      else if (pick < 83)
         h = 8'd240;
      else if (pick < 90)
         h = 8'd255;
      else if (pick < 95)
         h = 8'd1;
      else
         h = 8'($urandom_range(1, 255));
      program_frame(w, h, 2'($urandom_range(3)));
      sent = 0;
      while (sent < n_beats) begin
         if (sent == n_beats / 2)
            wait_until_drained();
         c = random_cmd();
         // Beats the block ignores do not count toward the phase.
         if (c.op != OP_NONE)
            sent++;
         send_cmd(c);
      end
   endtask

   task automatic test_random_drawing(input int idle_pct);
      sender_idle_pct = idle_pct;
      for (int i = 0; i < 4; i++)
         run_random_phase(142);
   endtask

   // ----------------------------------------------------------------------
   // Main sequence.
   // ----------------------------------------------------------------------
   initial begin
      // Every input is known from time zero; reset is released at a falling edge.
      reset            = 1'b1;
      start            = 1'b0;
      req_op           = OP_PLOT;
      req_x_pos        = '0;
      req_y_pos        = '0;
      req_rect_width   = '0;
      req_rect_height  = '0;
      req_color        = '0;
      req_read_address = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_FRAME_WIDTH;
      csr_data         = '0;
      fail_count       = 0;
      sender_idle_pct  = 0;
      last_pixel       = 0;
      cfg_width        = RST_FRAME_WIDTH;
      cfg_height       = RST_FRAME_HEIGHT;
      cfg_format       = FMT_RGB565;
      foreach (frame_bytes[i])
         frame_bytes[i] = 8'h00;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The block first clears the whole store with busy high; the first beat
      // simply waits for it.
      test_cleared_store();
      test_plot_clipping();
      test_full_frame_fill();
      test_rgb444_shared_nibble();
      test_rgb332_oversized();
      test_empty_frame();

      // The register settings are not restored in between: each random phase
      // reinterprets whatever the previous ones left in the store.
      test_random_drawing(17);
      test_random_drawing(47);
      test_random_drawing(0);

      wait_until_drained();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * 4);
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
rtl/mffw_pkg.sv
rtl/mffw_ram.sv
rtl/multi_format_framebuffer_writer_top.sv
sim/tb_top.sv
